>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pdll_pkg.sv
// ---------------------------------------------------------------------------
// pdll_pkg
// command, status and sequencer types of the pooled linked list
// ---------------------------------------------------------------------------
package pdll_pkg;

  localparam logic [2:0] CMD_RESERVED = 3'd7;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_RM_VAL   = 3'd3,
    OP_RM_HDL   = 3'd4,
    OP_WALK_FWD = 3'd5,
    OP_WALK_BWD = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_W1,
    S_ADD_W2,
    S_PEEK_DT,
    S_UL_A,
    S_UL_B,
    S_RV_RD,
    S_RV_CK,
    S_WK_EM,
    S_EMIT
  } state_t;

endpackage

>>> design/pdll_ram.sv
// ---------------------------------------------------------------------------
// pdll_ram
// generic single write, single registered read memory
// ---------------------------------------------------------------------------
module pdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/pdll_fifo.sv
// ---------------------------------------------------------------------------
// pdll_fifo
// small register queue with full and empty flags
// ---------------------------------------------------------------------------
module pdll_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> design/pdll_front.sv
// ---------------------------------------------------------------------------
// pdll_front
// takes commands, drops reserved codes, queues decoded commands
// ---------------------------------------------------------------------------
module pdll_front #(
  parameter int DW = 32,
  parameter int HW = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [2:0]      command,
  input  logic [DW-1:0]   data_value,
  input  logic [HW-1:0]   node_handle,
  output logic            cmd_valid,
  input  logic            cmd_pop,
  output pdll_pkg::op_t   cmd_op,
  output logic [DW-1:0]   cmd_data,
  output logic [HW-1:0]   cmd_handle
);

  localparam int QW = 3 + DW + HW;

  logic          q_push;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  // reserved codes are taken and produce nothing
  assign q_push  = push && (command != pdll_pkg::CMD_RESERVED);
  assign q_wdata = {command, data_value, node_handle};

  pdll_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid  = !q_empty;
  assign cmd_op     = pdll_pkg::op_t'(q_rdata[QW-1 -: 3]);
  assign cmd_data   = q_rdata[HW +: DW];
  assign cmd_handle = q_rdata[HW-1:0];

endmodule

>>> design/pdll_back.sv
// ---------------------------------------------------------------------------
// pdll_back
// list sequencer: node memories, free list, link updates and walks
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pdll_back #(
  parameter int CAPACITY = 16,
  parameter int DW       = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  pdll_pkg::op_t                   cmd_op,
  input  logic [DW-1:0]                   cmd_data,
  input  logic [$clog2(CAPACITY)-1:0]     cmd_handle,
  output logic                            out_push,
  input  logic                            out_full,
  output pdll_pkg::status_t               out_status,
  output logic [$clog2(CAPACITY)-1:0]     out_handle,
  output logic [DW-1:0]                   out_data,
  output logic [$clog2(CAPACITY+1)-1:0]   out_count,
  output logic                            out_last
);

  localparam int HW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  pdll_pkg::state_t  state, state_next;

  logic [LW-1:0]     head, tail, free_head, used, n, p, x, steps;
  pdll_pkg::op_t     op_q;
  logic [DW-1:0]     value_q;
  logic [CAPACITY-1:0] occ, nv, pv;

  logic              re;
  logic [HW-1:0]     raddr, rd_addr_q;
  logic              nv_q, pv_q;
  logic              d_we, n_we, p_we;
  logic [HW-1:0]     d_waddr, n_waddr, p_waddr;
  logic [LW-1:0]     n_wdata, p_wdata;
  logic [DW-1:0]     d_rdata;
  logic [LW-1:0]     n_rdata, p_rdata, next_eff, prev_eff, nx;
  logic              walk_last;
  logic [LW-1:0]     start;
  logic              hdl_bad;

  pdll_pkg::status_t res_status;
  logic [HW-1:0]     res_handle;
  logic [DW-1:0]     res_data;

  pdll_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(value_q),
    .re(re), .raddr(raddr), .rdata(d_rdata)
  );
  pdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(re), .raddr(raddr), .rdata(n_rdata)
  );
  pdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(re), .raddr(raddr), .rdata(p_rdata)
  );

  // links never written read as their reset pattern
  assign next_eff  = nv_q ? n_rdata : ((rd_addr_q == '0) ? NIL : LW'(rd_addr_q) - 1'b1);
  assign prev_eff  = pv_q ? p_rdata : NIL;
  assign nx        = (op_q == pdll_pkg::OP_WALK_FWD) ? next_eff : prev_eff;
  assign walk_last = (nx == NIL) || (steps == NIL - 1'b1);
  assign start     = (cmd_op == pdll_pkg::OP_WALK_FWD) ? head : tail;
  assign hdl_bad   = (LW'(cmd_handle) >= NIL) || !occ[cmd_handle];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    re         = 1'b0;
    raddr      = n[HW-1:0];
    d_we       = 1'b0;
    n_we       = 1'b0;
    p_we       = 1'b0;
    d_waddr    = n[HW-1:0];
    n_waddr    = n[HW-1:0];
    p_waddr    = n[HW-1:0];
    n_wdata    = head;
    p_wdata    = NIL;
    out_push   = 1'b0;
    out_status = res_status;
    out_handle = res_handle;
    out_data   = res_data;
    out_count  = used;
    out_last   = 1'b1;
    case (state)
      pdll_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = pdll_pkg::S_EMIT;
          case (cmd_op)
            pdll_pkg::OP_ADD: begin
              if (used != NIL) begin
                re         = 1'b1;
                raddr      = free_head[HW-1:0];
                state_next = pdll_pkg::S_ADD_W1;
              end
            end
            pdll_pkg::OP_POP, pdll_pkg::OP_PEEK: begin
              if (head != NIL) begin
                re         = 1'b1;
                raddr      = head[HW-1:0];
                state_next = (cmd_op == pdll_pkg::OP_POP) ? pdll_pkg::S_UL_A
                                                          : pdll_pkg::S_PEEK_DT;
              end
            end
            pdll_pkg::OP_RM_VAL: state_next = pdll_pkg::S_RV_RD;
            pdll_pkg::OP_RM_HDL: begin
              if (!hdl_bad) begin
                re         = 1'b1;
                raddr      = cmd_handle;
                state_next = pdll_pkg::S_UL_A;
              end
            end
            pdll_pkg::OP_WALK_FWD, pdll_pkg::OP_WALK_BWD: begin
              if (start != NIL) begin
                re         = 1'b1;
                raddr      = start[HW-1:0];
                state_next = pdll_pkg::S_WK_EM;
              end
            end
            default: state_next = pdll_pkg::S_IDLE;
          endcase
        end
      end
      pdll_pkg::S_ADD_W1: begin
        d_we       = 1'b1;
        n_we       = 1'b1;
        p_we       = 1'b1;
        state_next = (head != NIL) ? pdll_pkg::S_ADD_W2 : pdll_pkg::S_EMIT;
      end
      pdll_pkg::S_ADD_W2: begin
        p_we       = 1'b1;
        p_waddr    = head[HW-1:0];
        p_wdata    = n;
        state_next = pdll_pkg::S_EMIT;
      end
      pdll_pkg::S_PEEK_DT: state_next = pdll_pkg::S_EMIT;
      pdll_pkg::S_UL_A: begin
        n_we       = (prev_eff != NIL);
        n_waddr    = prev_eff[HW-1:0];
        n_wdata    = next_eff;
        p_we       = (next_eff != NIL);
        p_waddr    = next_eff[HW-1:0];
        p_wdata    = prev_eff;
        state_next = pdll_pkg::S_UL_B;
      end
      pdll_pkg::S_UL_B: begin
        n_we       = 1'b1;
        n_wdata    = free_head;
        p_we       = 1'b1;
        state_next = pdll_pkg::S_EMIT;
      end
      pdll_pkg::S_RV_RD: begin
        if (n == NIL || steps == NIL) begin
          state_next = pdll_pkg::S_EMIT;
        end else begin
          re         = 1'b1;
          state_next = pdll_pkg::S_RV_CK;
        end
      end
      pdll_pkg::S_RV_CK: begin
        if (d_rdata == value_q) begin
          re         = 1'b1;
          state_next = pdll_pkg::S_UL_A;
        end else begin
          state_next = pdll_pkg::S_RV_RD;
        end
      end
      pdll_pkg::S_WK_EM: begin
        out_push   = !out_full;
        out_status = pdll_pkg::ST_OK;
        out_handle = n[HW-1:0];
        out_data   = d_rdata;
        out_last   = walk_last;
        if (!out_full) begin
          if (walk_last) begin
            state_next = pdll_pkg::S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = nx[HW-1:0];
          end
        end
      end
      pdll_pkg::S_EMIT: begin
        out_push = !out_full;
        if (!out_full) begin
          state_next = pdll_pkg::S_IDLE;
        end
      end
      default: state_next = pdll_pkg::S_IDLE;
    endcase
  end

  // list registers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      free_head <= NIL - 1'b1;
      used      <= '0;
      occ       <= '0;
      nv        <= '0;
      pv        <= '0;
    end else begin
      if (n_we) begin
        nv[n_waddr] <= 1'b1;
      end
      if (p_we) begin
        pv[p_waddr] <= 1'b1;
      end
      case (state)
        pdll_pkg::S_ADD_W1: begin
          free_head <= next_eff;
          occ[n[HW-1:0]] <= 1'b1;
          if (head == NIL) begin
            head <= n;
            tail <= n;
            used <= used + 1'b1;
          end
        end
        pdll_pkg::S_ADD_W2: begin
          head <= n;
          used <= used + 1'b1;
        end
        pdll_pkg::S_UL_B: begin
          if (head == n) begin
            head <= x;
          end
          if (tail == n) begin
            tail <= p;
          end
          free_head      <= n;
          occ[n[HW-1:0]] <= 1'b0;
          used           <= used - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (re) begin
      rd_addr_q <= raddr;
      nv_q      <= nv[raddr];
      pv_q      <= pv[raddr];
    end
    case (state)
      pdll_pkg::S_IDLE: begin
        op_q       <= cmd_op;
        value_q    <= cmd_data;
        steps      <= '0;
        res_handle <= '0;
        res_data   <= '0;
        case (cmd_op)
          pdll_pkg::OP_ADD: begin
            n          <= free_head;
            res_status <= pdll_pkg::ST_FULL;
          end
          pdll_pkg::OP_RM_HDL: begin
            n          <= LW'(cmd_handle);
            res_status <= pdll_pkg::ST_NOT_FOUND;
          end
          pdll_pkg::OP_WALK_FWD, pdll_pkg::OP_WALK_BWD: begin
            n          <= start;
            res_status <= pdll_pkg::ST_EMPTY;
          end
          pdll_pkg::OP_RM_VAL: begin
            n          <= head;
            res_status <= pdll_pkg::ST_NOT_FOUND;
          end
          default: begin
            n          <= head;
            res_status <= pdll_pkg::ST_EMPTY;
          end
        endcase
      end
      pdll_pkg::S_ADD_W1: begin
        res_status <= pdll_pkg::ST_OK;
        res_handle <= n[HW-1:0];
      end
      pdll_pkg::S_PEEK_DT: begin
        res_status <= pdll_pkg::ST_OK;
        res_handle <= n[HW-1:0];
        res_data   <= d_rdata;
      end
      pdll_pkg::S_UL_A: begin
        p        <= prev_eff;
        x        <= next_eff;
        res_data <= d_rdata;
      end
      pdll_pkg::S_UL_B: begin
        res_status <= pdll_pkg::ST_OK;
        res_handle <= n[HW-1:0];
      end
      pdll_pkg::S_RV_CK: begin
        if (d_rdata != value_q) begin
          n     <= next_eff;
          steps <= steps + 1'b1;
        end
      end
      pdll_pkg::S_WK_EM: begin
        if (!out_full && !walk_last) begin
          n     <= nx;
          steps <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_used_bound, used <= NIL, "element count above capacity")
  `ASSERT_ALWAYS(a_head_used, (head == NIL) == (used == '0), "head and count disagree")
  `ASSERT_ALWAYS(a_head_tail, (head == NIL) == (tail == NIL), "head and tail disagree")
  `ASSERT_NEXT(a_emit_done, state == pdll_pkg::S_EMIT && !out_full,
               state == pdll_pkg::S_IDLE, "single result not retired")

endmodule

>>> design/pooled_doubly_linked_list.sv
// ---------------------------------------------------------------------------
// pooled_doubly_linked_list
// doubly linked list over a fixed node pool with a last-in-first-out free list
// ---------------------------------------------------------------------------
// channel  | handshake          | fields
// command  | push / full        | command, data_value, node_handle
// result   | pop / empty        | status, result_handle, data_out,
//          |                    | element_count, last_result
//
// add, pop, peek and remove by handle go straight to the result when full, empty
// or not found; the node memories have one registered read port each
// remove by value reads and checks each node in turn, then unlinks the match
// walks read the first node, then emit one element per cycle when not stalled
// synchronous reset; no clearing pass, unwritten links read as reset values
// a full result queue stalls the sequencer, a full command queue stalls push
module pooled_doubly_linked_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      command,
  input  logic [DATA_WIDTH-1:0]           data_value,
  input  logic [$clog2(CAPACITY)-1:0]     node_handle,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status,
  output logic [$clog2(CAPACITY)-1:0]     result_handle,
  output logic [DATA_WIDTH-1:0]           data_out,
  output logic [$clog2(CAPACITY+1)-1:0]   element_count,
  output logic                            last_result
);

  localparam int HW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 2 + HW + DATA_WIDTH + CW + 1;

  logic                  cmd_valid, cmd_pop;
  pdll_pkg::op_t         cmd_op;
  logic [DATA_WIDTH-1:0] cmd_data;
  logic [HW-1:0]         cmd_handle;
  logic                  out_push, out_full, out_last;
  pdll_pkg::status_t     out_status;
  logic [HW-1:0]         out_handle;
  logic [DATA_WIDTH-1:0] out_data;
  logic [CW-1:0]         out_count;
  logic [RW-1:0]         r_rdata;

  pdll_front #(.DW(DATA_WIDTH), .HW(HW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .data_value  (data_value),
    .node_handle (node_handle),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd_op      (cmd_op),
    .cmd_data    (cmd_data),
    .cmd_handle  (cmd_handle)
  );

  pdll_back #(.CAPACITY(CAPACITY), .DW(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_op     (cmd_op),
    .cmd_data   (cmd_data),
    .cmd_handle (cmd_handle),
    .out_push   (out_push),
    .out_full   (out_full),
    .out_status (out_status),
    .out_handle (out_handle),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  pdll_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({out_status, out_handle, out_data, out_count, out_last}),
    .full  (out_full),
    .pop   (pop),
    .rdata (r_rdata),
    .empty (empty)
  );

  assign {status, result_handle, data_out, element_count, last_result} = r_rdata;

endmodule
